/* rtl/rtbwu_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rtbwu_pkg
// Shared constants, types and helpers for the real-time block write unpacker.
// ---------------------------------------------------------------------------
package rtbwu_pkg;

  localparam int QUAD_W = 32;
  localparam int LEN_W  = 8;
  localparam int ADDR_W = 12;

  localparam logic [QUAD_W-1:0] LEN_MASK   = 32'h0000_00ff;
  localparam logic [QUAD_W-1:0] WRITE_BITS = 32'ha000_0000;
  localparam logic [QUAD_W-1:0] PWR_MASK   = 32'h000f_ffff;

  // Address of the power control register
  localparam logic [ADDR_W-1:0] PWR_ADDR = 12'h000;

  // Result kinds
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ERROR = 1'b1
  } kind_t;

  // One incoming block quadlet
  typedef struct packed {
    logic [QUAD_W-1:0] quad_raw;
    logic [LEN_W-1:0]  block_quads;
    logic              start_req;
  } item_t;

  // Decoded result of one quadlet
  typedef struct packed {
    logic              hit;
    kind_t             kind;
    logic [ADDR_W-1:0] wr_addr;
    logic [QUAD_W-1:0] wr_data;
    logic              block_end;
  } result_t;

  // Swap bus byte order into register order
  function automatic logic [QUAD_W-1:0] swap32(input logic [QUAD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

/* rtl/rtbwu_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rtbwu_core
// Block position tracking and per-quadlet decode into register writes and header mismatch errors.
// ---------------------------------------------------------------------------
module rtbwu_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire rtbwu_pkg::item_t  item,
  output rtbwu_pkg::result_t     res
);
  import rtbwu_pkg::*;

  logic [LEN_W-1:0] position, position_next;
  logic             no_middle_write, no_middle_write_next;
  logic             discarding, discarding_next;

  logic [QUAD_W-1:0] q;
  logic [LEN_W-1:0]  len;
  logic              len_ok;
  logic              at_last;

  assign q       = swap32(item.quad_raw);
  assign len     = item.block_quads;
  assign len_ok  = (len != '0) && ((q & LEN_MASK) == {{(QUAD_W-LEN_W){1'b0}}, len});
  assign at_last = ({1'b0, position} + (LEN_W+1)'(1)) >= {1'b0, len};

  // Decode the quadlet against the block state
  always_comb begin
    position_next        = position;
    no_middle_write_next = no_middle_write;
    discarding_next      = discarding;
    res.hit       = 1'b0;
    res.kind      = KIND_WRITE;
    res.wr_addr   = PWR_ADDR;
    res.wr_data   = q;
    res.block_end = 1'b0;
    if (item.start_req) begin
      no_middle_write_next = 1'b1;
      position_next        = LEN_W'(1);
      discarding_next      = 1'b1;
      if (!len_ok) begin
        res.hit       = 1'b1;
        res.kind      = KIND_ERROR;
        res.block_end = (len == LEN_W'(1));
      end else if (len == LEN_W'(1)) begin
        res.hit       = 1'b1;
        res.block_end = 1'b1;
      end else begin
        discarding_next = 1'b0;
      end
    end else if (!discarding) begin
      if (at_last) begin
        discarding_next = 1'b1;
        res.block_end   = 1'b1;
        res.hit         = no_middle_write || ((q & PWR_MASK) != '0);
      end else begin
        position_next = position + LEN_W'(1);
        if ((q & WRITE_BITS) != '0) begin
          no_middle_write_next = 1'b0;
          res.hit     = 1'b1;
          res.wr_addr = {position, 4'h1};
        end
      end
    end
  end

  // Advance block state on each processed quadlet
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      no_middle_write <= 1'b1;
      discarding      <= 1'b1;
    end else if (fire) begin
      position        <= position_next;
      no_middle_write <= no_middle_write_next;
      discarding      <= discarding_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/realtime_block_write_unpacker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// realtime_block_write_unpacker
// Turns a real-time write block, one quadlet per request, into register
// writes and header mismatch errors.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one block quadlet per request: tdata[31:0] the quadlet in
//   bus byte order, tdata[39:32] the block length in quadlets, tuser high on
//   the header quadlet. m_axis carries at most one result per quadlet:
//   tdata[11:0] register address, tdata[43:12] swapped data, tuser the kind
//   (0 write, 1 header mismatch), tlast high when it comes from the block's
//   last quadlet. Quadlets that cause no write are consumed silently.
//   An input register and a result register, with the decode between
//   them, lie between input request and result. Throughput is one
//   quadlet per cycle; the input is taken while a result waits, as long as
//   the input register can move on. A stalled receiver holds the result and,
//   after one more quadlet fills the input register, backpressures s_axis.
//   Reset empties both registers and drops input until the next header.
// ---------------------------------------------------------------------------
module realtime_block_write_unpacker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // quad_raw[31:0], block_quads[39:32]
  input  wire logic        s_axis_tuser,   // start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // wr_addr[11:0], wr_data[43:12], zero pad
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast    // block_end
);
  import rtbwu_pkg::*;

  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t res;

  logic              out_valid;
  kind_t             out_kind;
  logic [ADDR_W-1:0] out_addr;
  logic [QUAD_W-1:0] out_data;
  logic              out_last;

  // Decode step fires when the result register can take a result
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.quad_raw    <= s_axis_tdata[31:0];
      in_item.block_quads <= s_axis_tdata[39:32];
      in_item.start_req   <= s_axis_tuser;
    end
  end

  rtbwu_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .res  (res)
  );

  // Result register: load on a hit, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.hit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_kind <= res.kind;
      out_addr <= res.wr_addr;
      out_data <= res.wr_data;
      out_last <= res.block_end;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_data, out_addr};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // Error results never carry a write address
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_ERROR)) |-> (m_axis_tdata[11:0] == PWR_ADDR))
    else $error("error result with nonzero address");

  // Middle writes use address low nibble 1 and never end the block
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[11:0] != PWR_ADDR))
      |-> (m_axis_tdata[3:0] == 4'h1 && !m_axis_tlast && m_axis_tuser == KIND_WRITE))
    else $error("malformed middle write");

  // Writes from the last quadlet go to power control
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && (m_axis_tuser == KIND_WRITE))
      |-> (m_axis_tdata[11:0] == PWR_ADDR))
    else $error("last quadlet write not at power control");

  // Backpressure only when the input register is full and blocked
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without cause");

  // A stalled item is decoded in the cycle the receiver takes the result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && m_axis_tready) |-> advance)
    else $error("decode did not advance on result take");

endmodule
`default_nettype wire
